@@ hw/rtl/pngu_pkg.sv @@
// Shared types and constants for the PNG scanline unfilter.
// Used by png_scanline_unfilter; depends on nothing.

package pngu_pkg;

    // Filter-type codes carried in the byte that opens a scanline
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 2;
    localparam logic [1:0] REG_LINE_BYTES  = 2'd0;
    localparam logic [1:0] REG_PIXEL_BYTES = 2'd1;

    // Configuration data port width and register reset values
    localparam int          CFG_DATA_W        = 14;
    localparam logic [13:0] LINE_BYTES_RESET  = 14'd3;
    localparam logic [3:0]  PIXEL_BYTES_RESET = 4'd3;

    // Output queue: four entries cover the read pipeline and the skid
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // Operation handed from the accept stage to the reconstruction stage
    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_DATA,
        OP_BAD
    } op_t;

    // One result beat
    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       last_in_line;
        logic       bad_filter;
    } result_t;

endpackage

@@ hw/rtl/png_scanline_unfilter.sv @@
// Top level of the PNG scanline unfilter: reverses none/sub/up/average/Paeth filtering.
// Depends on pngu_pkg and pngu_ram (previous-line store).
//
//  channel | signals                                   | direction | accepted when
//  --------+-------------------------------------------+-----------+-----------------------
//  in      | value, line_start, image_start            | sink      | in_valid & in_ready
//  out     | pixel_byte, last_in_line, bad_filter      | source    | out_valid & out_ready
//  cfg     | cfg_index, cfg_data                       | sink      | cfg_valid & cfg_ready
//
// One input beat per cycle while the output queue has room. A taken data byte is
// registered with its previous-line RAM read, then reconstructed into the output queue.
// Reset clears all control state at once; the previous-line RAM needs no clearing pass.
// On an output stall, in_ready drops once queued and in-flight beats reach four.
// cfg_ready is always high.

module png_scanline_unfilter
    import pngu_pkg::*;
#(
    parameter int MAX_LINE_BYTES  = 8192,
    parameter int MAX_PIXEL_BYTES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input beats
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            value,
    input  logic                  line_start,
    input  logic                  image_start,
    // result beats
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            pixel_byte,
    output logic                  last_in_line,
    output logic                  bad_filter,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W    = $clog2(MAX_LINE_BYTES);
    localparam int POS_W     = $clog2(MAX_LINE_BYTES + 1);
    localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // Configuration registers
    logic [13:0] line_bytes_reg;
    logic [3:0]  pixel_bytes_reg;

    // Accept-stage control state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [2:0]       filter_reg, filter_next;
    logic             first_reg, first_next;
    logic             halted_reg, halted_next;

    // Reconstruction-stage registers
    op_t               s1_op_reg, op_next;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_last_reg;
    logic [2:0]        s1_filter_reg;
    logic              s1_first_reg;
    logic [7:0]        s1_raw_reg;

    // Left and upper-left byte histories, newest at index 0
    logic [7:0] left_hist_reg  [MAX_PIXEL_BYTES];
    logic [7:0] upper_hist_reg [MAX_PIXEL_BYTES];

    // Output queue
    result_t              q_mem_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] q_wr_reg, q_rd_reg;
    logic [OUT_CNT_W-1:0] q_cnt_reg;

    logic             accept;
    logic [POS_W-1:0] len_eff;
    logic             last_next;
    logic             rd_en;
    logic [7:0]       ram_rdata;

    logic [3:0]           pix_eff;
    logic [PIX_IDX_W-1:0] pix_idx;
    logic [7:0]           left_b, above_b, upper_b, pred_b, rec_b;
    logic                 s1_push, q_pop;
    result_t              s1_result;

    // Paeth predictor, ties go left, then above, then upper-left
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [10:0] pa_s, pb_s, pc_s;
        logic        [10:0] pa, pb, pc;
        pa_s = $signed({3'b0, b}) - $signed({3'b0, c});
        pb_s = $signed({3'b0, a}) - $signed({3'b0, c});
        pc_s = $signed({3'b0, a}) + $signed({3'b0, b}) - $signed({2'b0, c, 1'b0});
        pa   = pa_s[10] ? 11'(-pa_s) : 11'(pa_s);
        pb   = pb_s[10] ? 11'(-pb_s) : 11'(pb_s);
        pc   = pc_s[10] ? 11'(-pc_s) : 11'(pc_s);
        if ((pa <= pb) && (pa <= pc))
        begin
            return a;
        end
        else if (pb <= pc)
        begin
            return b;
        end
        return c;
    endfunction

    // Effective line length, clamped to 1..MAX_LINE_BYTES
    always_comb
    begin
        if (line_bytes_reg == 14'd0)
        begin
            len_eff = POS_W'(1);
        end
        else if (32'(line_bytes_reg) > 32'(MAX_LINE_BYTES))
        begin
            len_eff = POS_W'(MAX_LINE_BYTES);
        end
        else
        begin
            len_eff = POS_W'(line_bytes_reg);
        end
    end

    // Effective pixel size, clamped to 1..MAX_PIXEL_BYTES
    always_comb
    begin
        if (pixel_bytes_reg == 4'd0)
        begin
            pix_eff = 4'd1;
        end
        else if (pixel_bytes_reg > 4'(MAX_PIXEL_BYTES))
        begin
            pix_eff = 4'(MAX_PIXEL_BYTES);
        end
        else
        begin
            pix_eff = pixel_bytes_reg;
        end
    end
    assign pix_idx = PIX_IDX_W'(pix_eff - 4'd1);

    // Configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_bytes_reg  <= LINE_BYTES_RESET;
            pixel_bytes_reg <= PIXEL_BYTES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LINE_BYTES:  line_bytes_reg  <= cfg_data;
                REG_PIXEL_BYTES: pixel_bytes_reg <= cfg_data[3:0];
                default:         ;
            endcase
        end
    end

    // Input flow control: room for whatever is already in flight
    assign s1_push  = (s1_op_reg == OP_DATA) || (s1_op_reg == OP_BAD);
    assign in_ready = (4'(q_cnt_reg) + 4'(s1_push)) < 4'(OUT_DEPTH);
    assign accept   = in_valid && in_ready;

    // Accept stage: line framing, halt handling and RAM read issue
    assign last_next = (pos_reg + POS_W'(1)) == len_eff;

    always_comb
    begin
        op_next     = OP_NONE;
        pos_next    = pos_reg;
        filter_next = filter_reg;
        first_next  = first_reg;
        halted_next = halted_reg;
        rd_en       = 1'b0;
        if (accept && (!halted_reg || (line_start && image_start)))
        begin
            if (line_start)
            begin
                pos_next    = '0;
                halted_next = 1'b0;
                if (value > 8'(FILT_PAETH))
                begin
                    halted_next = 1'b1;
                    first_next  = 1'b1;
                    op_next     = OP_BAD;
                end
                else
                begin
                    filter_next = value[2:0];
                    first_next  = image_start;
                    op_next     = OP_CLEAR;
                end
            end
            else if (pos_reg < len_eff)
            begin
                op_next  = OP_DATA;
                rd_en    = 1'b1;
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            filter_reg <= FILT_NONE;
            first_reg  <= 1'b1;
            halted_reg <= 1'b0;
            s1_op_reg  <= OP_NONE;
        end
        else
        begin
            pos_reg    <= pos_next;
            filter_reg <= filter_next;
            first_reg  <= first_next;
            halted_reg <= halted_next;
            s1_op_reg  <= op_next;
        end
    end

    // Stage payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg   <= ADDR_W'(pos_reg);
            s1_last_reg   <= last_next;
            s1_filter_reg <= filter_reg;
            s1_first_reg  <= first_reg;
            s1_raw_reg    <= value;
        end
    end

    // Previous-line store; the write of byte n never meets the read of the same entry
    pngu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_above_ram (
        .clk   (clk),
        .we    (s1_op_reg == OP_DATA),
        .waddr (s1_addr_reg),
        .wdata (rec_b),
        .re    (rd_en),
        .raddr (ADDR_W'(pos_reg)),
        .rdata (ram_rdata)
    );

    // Reconstruction stage
    assign left_b  = left_hist_reg[pix_idx];
    assign upper_b = upper_hist_reg[pix_idx];
    assign above_b = s1_first_reg ? 8'd0 : ram_rdata;

    always_comb
    begin
        case (s1_filter_reg)
            FILT_SUB:   pred_b = left_b;
            FILT_UP:    pred_b = above_b;
            FILT_AVG:   pred_b = 8'((9'(left_b) + 9'(above_b)) >> 1);
            FILT_PAETH: pred_b = paeth(left_b, above_b, upper_b);
            default:    pred_b = 8'd0;
        endcase
    end
    assign rec_b = s1_raw_reg + pred_b;

    // History shift registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]  <= 8'd0;
                upper_hist_reg[i] <= 8'd0;
            end
        end
        else if ((s1_op_reg == OP_CLEAR) || (s1_op_reg == OP_BAD))
        begin
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]  <= 8'd0;
                upper_hist_reg[i] <= 8'd0;
            end
        end
        else if (s1_op_reg == OP_DATA)
        begin
            left_hist_reg[0]  <= rec_b;
            upper_hist_reg[0] <= above_b;
            for (int i = 1; i < MAX_PIXEL_BYTES; i++)
            begin
                left_hist_reg[i]  <= left_hist_reg[i-1];
                upper_hist_reg[i] <= upper_hist_reg[i-1];
            end
        end
    end

    // Result beat for the queue
    always_comb
    begin
        if (s1_op_reg == OP_BAD)
        begin
            s1_result = '{pixel_byte: 8'd0, last_in_line: 1'b0, bad_filter: 1'b1};
        end
        else
        begin
            s1_result = '{pixel_byte: rec_b, last_in_line: s1_last_reg, bad_filter: 1'b0};
        end
    end

    // Output queue
    assign out_valid = (q_cnt_reg != '0);
    assign q_pop     = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end
        else
        begin
            if (s1_push)
            begin
                q_wr_reg <= q_wr_reg + OUT_PTR_W'(1);
            end
            if (q_pop)
            begin
                q_rd_reg <= q_rd_reg + OUT_PTR_W'(1);
            end
            q_cnt_reg <= q_cnt_reg + OUT_CNT_W'(s1_push) - OUT_CNT_W'(q_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_push)
        begin
            q_mem_reg[q_wr_reg] <= s1_result;
        end
    end

    assign pixel_byte   = q_mem_reg[q_rd_reg].pixel_byte;
    assign last_in_line = q_mem_reg[q_rd_reg].last_in_line;
    assign bad_filter   = q_mem_reg[q_rd_reg].bad_filter;

endmodule

@@ hw/rtl/pngu_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.

module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
